// File: src/lsr_pkg.sv
// Package for the literal substring replacer: beat structs, register
// indexes, opcodes and the packed-byte selector.
// No dependencies; every other source file imports it.
`default_nettype none
package lsr_pkg;

  localparam int BYTES_W = 64;
  localparam int LEN_W   = 4;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_PAT_BYTES = 2'd0,
    REG_PAT_LEN   = 2'd1,
    REG_REP_BYTES = 2'd2,
    REG_REP_LEN   = 2'd3
  } reg_index_t;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } out_item_t;

  // Byte idx of a register packed with its first byte in bits 7..0.
  function automatic logic [7:0] packed_byte(input logic [BYTES_W-1:0] bytes,
                                             input logic [2:0] idx);
    packed_byte = bytes[{idx, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// File: src/literal_substring_replacer.sv
// Top level of the literal substring replacer: configuration registers,
// the chain of window cells, the output sequencer and the output register.
// Depends on lsr_pkg and lsr_cell.
//
//   Port group | Direction | Handshake           | Beat contents
//   in_*       | input     | in_valid/in_ready   | in_item_t: op, data_byte
//   out_*      | output    | out_valid/out_ready | out_item_t: out_byte, byte_valid, last
//   cfg_*      | input     | cfg_we only         | cfg_index, cfg_wdata
//
// An input beat is taken every cycle while the output register is free or
// being drained. A beat that yields n > 1 output beats (a replacement longer
// than one byte, or an end-of-string flush of n window bytes) holds in_ready
// low while the output sequencer walks the remaining bytes.
// rst_n is synchronous and active low; it clears the configuration, the
// window fill count, the sequencer state and out_valid. A stall on out_ready
// holds the output beat and, once the output register is full, the input.
`default_nettype none
module literal_substring_replacer #(
  parameter int PATTERN_MAX     = 8,
  parameter int REPLACEMENT_MAX = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lsr_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lsr_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [lsr_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [lsr_pkg::BYTES_W-1:0]   cfg_wdata
);
  import lsr_pkg::*;

  // Lengths saturate at the smaller of the parameter and the eight bytes a
  // 64-bit register holds.
  localparam int WIN_DEPTH = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
  localparam int REP_LIM   = (REPLACEMENT_MAX < 8) ? REPLACEMENT_MAX : 8;
  localparam logic [LEN_W-1:0] PLIM = LEN_W'(WIN_DEPTH);
  localparam logic [LEN_W-1:0] RLIM = LEN_W'(REP_LIM);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_FLUSH = 3'b010,
    ST_REPL  = 3'b100
  } seq_state_t;

  // Configuration registers.
  logic [BYTES_W-1:0] pat_bytes_r;
  logic [LEN_W-1:0]   plen_r;
  logic [BYTES_W-1:0] rep_bytes_r;
  logic [LEN_W-1:0]   rlen_r;
  logic [LEN_W-1:0]   cfg_len;

  // Window and sequencer state.
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] rpos_r, rpos_nxt;
  seq_state_t       state_r, state_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Chain wiring.
  logic [7:0] cell_d [WIN_DEPTH];
  logic [7:0] cell_q [WIN_DEPTH];
  logic       cell_hit [WIN_DEPTH];
  logic       shift_en;
  logic       match;
  logic [7:0] win_oldest;
  logic [7:0] new_oldest;

  logic       load_ok;
  logic       accept;
  logic [LEN_W-1:0] count_inc;

  assign load_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_RUN) && load_ok;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign count_inc = count_r + LEN_W'(1);

  // A data byte enters the chain only when a pattern is configured.
  assign shift_en = accept && (in_data.op == OP_DATA) && (plen_r != '0);

  // Each cell takes its neighbor's byte on every shift; cell 0 takes the new byte.
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_d[k] = in_data.data_byte;
    end else begin : g_link
      assign cell_d[k] = cell_q[k-1];
    end
    lsr_cell #(.CELL_IDX(k)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (cell_d[k]),
      .plen     (plen_r),
      .pattern  (pat_bytes_r),
      .q        (cell_q[k]),
      .hit      (cell_hit[k])
    );
  end

  // The window with the new byte matches when every cell agrees.
  // win_oldest is the oldest stored byte, new_oldest the oldest once the new
  // byte is counted in.
  always_comb begin
    match      = 1'b1;
    win_oldest = '0;
    new_oldest = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      match = match & cell_hit[k];
      if (count_r == LEN_W'(k + 1)) begin
        win_oldest = cell_q[k];
      end
      if (plen_r == LEN_W'(k + 1)) begin
        new_oldest = cell_d[k];
      end
    end
  end

  always_comb begin
    cfg_len = cfg_wdata[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      plen_r      <= '0;
      rep_bytes_r <= '0;
      rlen_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_BYTES: pat_bytes_r <= cfg_wdata;
        REG_PAT_LEN:   plen_r      <= (cfg_len > PLIM) ? PLIM : cfg_len;
        REG_REP_BYTES: rep_bytes_r <= cfg_wdata;
        REG_REP_LEN:   rlen_r      <= (cfg_len > RLIM) ? RLIM : cfg_len;
        default: ;
      endcase
    end
  end

  // Sequencer: single-beat results load the output register at once; longer
  // ones load the first beat and leave the rest to the FLUSH or REPL state.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rpos_nxt      = rpos_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (in_data.op == OP_END) begin
            if (count_r == '0) begin
              // Bare end marker.
              out_data_nxt  = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1};
              out_valid_nxt = 1'b1;
            end else begin
              out_data_nxt  = '{out_byte: win_oldest, byte_valid: 1'b1,
                                last: (count_r == LEN_W'(1))};
              out_valid_nxt = 1'b1;
              count_nxt     = count_r - LEN_W'(1);
              if (count_r != LEN_W'(1)) begin
                state_nxt = ST_FLUSH;
              end
            end
          end else if (plen_r == '0) begin
            // No pattern: pass the byte through.
            out_data_nxt  = '{out_byte: in_data.data_byte, byte_valid: 1'b1, last: 1'b0};
            out_valid_nxt = 1'b1;
          end else if (count_inc != plen_r) begin
            count_nxt = count_inc;
          end else if (match) begin
            count_nxt = '0;
            if (rlen_r != '0) begin
              out_data_nxt  = '{out_byte: packed_byte(rep_bytes_r, 3'd0),
                                byte_valid: 1'b1, last: 1'b0};
              out_valid_nxt = 1'b1;
              if (rlen_r != LEN_W'(1)) begin
                rpos_nxt  = LEN_W'(1);
                state_nxt = ST_REPL;
              end
            end
          end else begin
            // Full window without a match: release the oldest byte.
            out_data_nxt  = '{out_byte: new_oldest, byte_valid: 1'b1, last: 1'b0};
            out_valid_nxt = 1'b1;
            count_nxt     = plen_r - LEN_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (load_ok) begin
          out_data_nxt  = '{out_byte: win_oldest, byte_valid: 1'b1,
                            last: (count_r == LEN_W'(1))};
          out_valid_nxt = 1'b1;
          count_nxt     = count_r - LEN_W'(1);
          if (count_r == LEN_W'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_REPL: begin
        if (load_ok) begin
          out_data_nxt  = '{out_byte: packed_byte(rep_bytes_r, rpos_r[2:0]),
                            byte_valid: 1'b1, last: 1'b0};
          out_valid_nxt = 1'b1;
          rpos_nxt      = rpos_r + LEN_W'(1);
          if (rpos_r == rlen_r - LEN_W'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase

    // Changing the pattern length drops whatever the window holds.
    if (cfg_we && (cfg_index == REG_PAT_LEN)) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      rpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rpos_r      <= rpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: src/lsr_cell.sv
// One window cell: holds one byte of the window and compares the byte
// shifting into it with the pattern byte it lines up with.
// Depends on lsr_pkg.
`default_nettype none
module lsr_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         shift_en,
  input  wire logic [7:0]                   d,
  input  wire logic [lsr_pkg::LEN_W-1:0]    plen,
  input  wire logic [lsr_pkg::BYTES_W-1:0]  pattern,
  output logic      [7:0]                   q,
  output logic                              hit
);
  import lsr_pkg::*;

  localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_IDX);

  logic [7:0]       byte_r;
  logic             active;
  logic [LEN_W-1:0] pos;

  // Cell k holds the byte from k beats ago, so it faces pattern byte plen-1-k.
  assign active = IDX < plen;
  assign pos    = plen - IDX - LEN_W'(1);
  assign hit    = !active || (d == packed_byte(pattern, pos[2:0]));
  assign q      = byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d;
    end
  end

endmodule
`default_nettype wire

// File: dv/literal_substring_replacer_tb.sv
// Self-checking testbench for literal_substring_replacer: directed strings, then random
// strings under several pattern and replacement settings, checked against a built-in predictor.
// Depends on lsr_pkg and the literal_substring_replacer RTL only.
module literal_substring_replacer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsr_pkg::*;

  // Cycles allowed for the output sequencer to finish after the last expected beat, and the
  // longest run of cycles with no beat accepted on either channel before the run is abandoned.
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS   = 50;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [BYTES_W-1:0]   cfg_wdata = '0;

  literal_substring_replacer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Beats waiting to be driven, and rewritten-string beats the block still owes us.
  in_item_t  pending_beats[$];
  out_item_t expected_beats[$];

  // Idle rates in percent for the sender and the receiver; the main sequence changes them.
  int send_idle_pct = 9;
  int recv_idle_pct = 76;

  // Handshake outcomes seen at the last rising edge, read by the driver at the falling edge.
  bit in_taken;

  int errors        = 0;
  int queued_beats  = 0;
  int beats_in      = 0;
  int ends_in       = 0;
  int beats_out     = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  // Predictor state: the configuration as the block holds it and the bytes it is still
  // holding back because they might begin an occurrence of the pattern.
  logic [BYTES_W-1:0] cur_pattern;
  logic [LEN_W-1:0]   cur_pat_len;
  logic [BYTES_W-1:0] cur_repl;
  logic [LEN_W-1:0]   cur_repl_len;
  logic [7:0]         held_bytes[8];
  int                 held_count;

  // Lengths above eight cannot be backed by a 64-bit register, so the block saturates them.
  function automatic int clamp_len(logic [LEN_W-1:0] len);
    return (len > 8) ? 8 : int'(len);
  endfunction

  task automatic clear_predictor();
    cur_pattern  = '0;
    cur_pat_len  = '0;
    cur_repl     = '0;
    cur_repl_len = '0;
    held_count   = 0;
  endtask

  // A new pattern length throws away whatever the window holds, without emitting it.
  task automatic apply_register(logic [IDX_W-1:0] idx, logic [BYTES_W-1:0] value);
    case (reg_index_t'(idx))
      REG_PAT_BYTES: cur_pattern = value;
      REG_PAT_LEN: begin
        cur_pat_len = value[LEN_W-1:0];
        held_count  = 0;
      end
      REG_REP_BYTES: cur_repl = value;
      REG_REP_LEN:   cur_repl_len = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Works out the rewritten-string beats that one accepted input beat releases.
  task automatic predict_rewrite(in_item_t beat);
    int  plen;
    int  rlen;
    bit  hit;
    plen = clamp_len(cur_pat_len);
    rlen = clamp_len(cur_repl_len);
    if (held_count > plen) held_count = 0;
    if (beat.op == OP_END) begin
      // An end marker flushes the held bytes; with nothing held it becomes a bare end mark.
      if (held_count == 0) begin
        expected_beats.push_back(out_item_t'{8'h00, 1'b0, 1'b1});
      end else begin
        for (int i = 0; i < held_count; i++) begin
          expected_beats.push_back(out_item_t'{held_bytes[i], 1'b1, i == held_count - 1});
        end
        held_count = 0;
      end
    end else if (plen == 0) begin
      expected_beats.push_back(out_item_t'{beat.data_byte, 1'b1, 1'b0});
    end else begin
      held_bytes[held_count] = beat.data_byte;
      held_count++;
      if (held_count == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (held_bytes[i] != cur_pattern[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          // A match emits the replacement (possibly nothing) and starts a fresh window.
          for (int i = 0; i < rlen; i++) begin
            expected_beats.push_back(out_item_t'{cur_repl[8*i +: 8], 1'b1, 1'b0});
          end
          held_count = 0;
        end else begin
          // No match: release the oldest byte and slide the window by one.
          expected_beats.push_back(out_item_t'{held_bytes[0], 1'b1, 1'b0});
          for (int i = 1; i < plen; i++) held_bytes[i-1] = held_bytes[i];
          held_count = plen - 1;
        end
      end
    end
  endtask

  // Monitor. Register writes, accepted input beats and accepted output beats are all taken at
  // the rising edge. The prediction for an input beat goes in before the output beat of the
  // same edge is checked, so a block that answered within the cycle would still line up.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_predictor();
      in_taken = 1'b0;
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_wdata);
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        beats_in++;
        if (in_data.op == OP_END) ends_in++;
        predict_rewrite(in_data);
      end
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected output beat: byte %02h valid %0d last %0d", $time,
                   out_data.out_byte, out_data.byte_valid, out_data.last);
          errors++;
        end else if (out_data !== expected_beats[0]) begin
          $display("%0t: mismatch: expected byte %02h valid %0d last %0d, got byte %02h valid %0d last %0d",
                   $time, expected_beats[0].out_byte, expected_beats[0].byte_valid,
                   expected_beats[0].last, out_data.out_byte, out_data.byte_valid, out_data.last);
          errors++;
          void'(expected_beats.pop_front());
        end else begin
          void'(expected_beats.pop_front());
        end
      end
    end
  end

  // Driver. A beat that has been offered stays on the bus untouched until it is taken; after
  // that the next pending beat goes out unless the sender decides to idle this cycle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a correct block never sits this long without moving a beat on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles, %0d beats still pending, %0d expected",
                 $time, quiet_cycles, pending_beats.size(), expected_beats.size());
        $display("[literal_substring_replacer] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_byte(logic [7:0] b);
    pending_beats.push_back(in_item_t'{OP_DATA, b});
    queued_beats++;
  endtask

  // The data byte rides along with an end marker but carries nothing; the random strings randomize it.
  task automatic queue_end(logic [7:0] junk);
    pending_beats.push_back(in_item_t'{OP_END, junk});
    queued_beats++;
  endtask

  task automatic set_register(reg_index_t idx, logic [BYTES_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Writes all four registers; only called while no output is owed.
  task automatic load_setting(logic [BYTES_W-1:0] pattern, logic [LEN_W-1:0] pat_len,
                              logic [BYTES_W-1:0] repl, logic [LEN_W-1:0] repl_len);
    set_register(REG_PAT_BYTES, pattern);
    set_register(REG_PAT_LEN, pat_len);
    set_register(REG_REP_BYTES, repl);
    set_register(REG_REP_LEN, repl_len);
    settings_used++;
    @(posedge clk);
  endtask

  // Waits until every beat has been driven and answered, then gives the sequencer time to
  // finish any work that produces no beat, such as a byte that only fills the window.
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly letters from a tiny alphabet so that random text hits the pattern and its prefixes
  // often, with the all-zero and all-one bytes and fully random bytes mixed in.
  function automatic logic [BYTES_W-1:0] random_text_word();
    logic [BYTES_W-1:0] word;
    int                 roll;
    word = '0;
    for (int i = 0; i < 8; i++) begin
      roll = $urandom_range(9);
      if (roll < 6)      word[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
      else if (roll < 8) word[8*i +: 8] = (roll == 6) ? 8'h00 : 8'hFF;
      else               word[8*i +: 8] = 8'($urandom_range(255));
    end
    return word;
  endfunction

  // Random strings built from whole occurrences of the pattern, cut-off prefixes of it,
  // alphabet letters and raw bytes. Most strings close with an end marker; some run on into
  // the next string, and a few stray end markers arrive between strings.
  task automatic queue_random_strings(logic [BYTES_W-1:0] pattern, int plen, int count);
    int goal;
    int pieces;
    int cut;
    goal = queued_beats + count;
    while (queued_beats < goal) begin
      if ($urandom_range(99) < 8) begin
        queue_end(8'($urandom_range(255)));
      end else begin
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
          case ($urandom_range(9))
            0, 1, 2, 3: for (int k = 0; k < plen; k++) queue_byte(pattern[8*k +: 8]);
            4, 5: begin
              cut = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
              for (int k = 0; k < cut; k++) queue_byte(pattern[8*k +: 8]);
            end
            6, 7: queue_byte(($urandom_range(1) == 1) ? pattern[8*$urandom_range(7) +: 8]
                                                      : 8'h61 + 8'($urandom_range(2)));
            default: queue_byte(8'($urandom_range(255)));
          endcase
        end
        if ($urandom_range(99) < 85) queue_end(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [BYTES_W-1:0] pattern;
    logic [BYTES_W-1:0] repl;
    logic [LEN_W-1:0]   pat_len;
    logic [LEN_W-1:0]   repl_len;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset leaves a zero pattern length, so bytes pass straight through, the extremes of
    // the byte range among them, and every end marker is a bare end mark.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_end(8'hFF);
    queue_byte(8'h5A);
    wait_quiet();

    // Pattern "ab" with junk in the unused upper bytes, replaced by "XYZ": a failed start,
    // a match, a slide, a flush of one leftover byte, a bare end, and finally one byte
    // left in the window for the next pattern-length write to discard.
    load_setting(64'hFFFF_FFFF_FFFF_6261, 4'd2, 64'h0000_0000_005A_5958, 4'd3);
    queue_byte(8'h61);
    queue_byte(8'h61);
    queue_byte(8'h62);
    queue_byte(8'h63);
    queue_byte(8'h61);
    queue_end(8'h00);
    queue_end(8'h81);
    queue_byte(8'h61);
    wait_quiet();

    // Pattern length fifteen saturates to eight all-ones bytes and the replacement is empty:
    // a full match emits nothing, then a lone leftover byte is flushed by the end marker.
    load_setting('1, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd0);
    repeat (8) queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_end(8'h3C);
    wait_quiet();

    // Random part. The first two settings run with a mostly stalled receiver, the next two
    // with a mostly stalled sender, and the last two with no idling at all.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 9;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pattern  = random_text_word();
      repl     = {$urandom, $urandom};
      case (ph)
        0: begin
          pat_len  = 4'd1;
          repl     = '1;
          repl_len = 4'd8;
        end
        1: begin
          pat_len  = 4'd8;
          repl_len = 4'd1;
        end
        2: begin
          pattern  = '0;
          pat_len  = 4'd0;
          repl_len = 4'd3;
        end
        3: begin
          pat_len  = 4'd3;
          repl_len = 4'd0;
        end
        4: begin
          pat_len  = 4'($urandom_range(15));
          repl_len = 4'($urandom_range(15));
        end
        default: begin
          pat_len  = 4'd2;
          repl     = '0;
          repl_len = 4'd15;
        end
      endcase
      load_setting(pattern, pat_len, repl, repl_len);
      queue_random_strings(pattern, clamp_len(pat_len), PHASE_BEATS);
      wait_quiet();
    end

    $display("Covered %0d input beats (%0d end markers) and %0d output beats", beats_in,
             ends_in, beats_out);
    $display("under %0d register settings plus the reset defaults.", settings_used);
    if (errors == 0) begin
      $display("[literal_substring_replacer] OK");
    end else begin
      $display("[literal_substring_replacer] ERROR");
    end
    $finish;
  end

endmodule
